>>> design/lfu_pkg.sv
// Shared constants, types and helpers for the LFU page replacement block.
package lfu_pkg;

    localparam int FRAMES      = 16;
    localparam int IDX_W       = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NUM_W       = $clog2(FRAMES + 1);
    localparam int PAGE_W      = 16;
    localparam int CNT_W       = 16;
    localparam int FAULT_W     = 16;
    localparam int CFG_W       = 5;
    localparam int FIDX_W      = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } stat_t;

    // Register value clamped to 1..FRAMES
    function automatic logic [NUM_W-1:0] managed_frames(input logic [CFG_W-1:0] cfg);
        logic [NUM_W-1:0] n;
        n = NUM_W'(cfg);
        if (cfg == '0)
            n = NUM_W'(1);
        else if (int'(cfg) > FRAMES)
            n = NUM_W'(FRAMES);
        return n;
    endfunction

endpackage

>>> design/lfu_ctrl.sv
// Sequencing state machine: accept, frame scan, commit.
module lfu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  lfu_pkg::stat_t stat,
    output lfu_pkg::cmd_t  cmd
);
    import lfu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> design/lfu_dp.sv
// Frame store, scan registers, replacement update and result register.
module lfu_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfu_pkg::cmd_t                       cmd,
    output lfu_pkg::stat_t                      stat,
    input  logic [lfu_pkg::PAGE_W-1:0]          in_page,
    input  logic                                cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]           cfg_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lfu_pkg::OUT_TDATA_W-1:0]     out_data
);
    import lfu_pkg::*;

    logic [PAGE_W-1:0]  page_mem [FRAMES];
    logic [CNT_W-1:0]   count_mem [FRAMES];
    logic [FRAMES-1:0]  valid_reg;
    logic [NUM_W-1:0]   fill_reg;
    logic [FAULT_W-1:0] faults_reg;
    logic [CFG_W-1:0]   frames_cfg_reg;

    logic [PAGE_W-1:0]  page_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic [IDX_W-1:0]   min_idx_reg;
    logic [CNT_W-1:0]   min_cnt_reg;
    logic [PAGE_W-1:0]  min_page_reg;
    logic               min_valid_reg;

    logic               out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [NUM_W-1:0]   n;
    logic [PAGE_W-1:0]  cur_page;
    logic [CNT_W-1:0]   cur_cnt;
    logic               cur_valid;
    logic               hit_now;
    logic               last;
    logic               full;
    logic [IDX_W-1:0]   slot;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] faults_next;
    logic [CNT_W-1:0]   cnt_next;
    logic [OUT_TDATA_W-1:0] out_data_next;

    assign n         = managed_frames(frames_cfg_reg);
    assign cur_page  = page_mem[idx_reg];
    assign cur_cnt   = count_mem[idx_reg];
    assign cur_valid = valid_reg[idx_reg];
    assign hit_now   = cur_valid && (cur_page == page_reg);
    assign last      = (NUM_W'(idx_reg) == (n - NUM_W'(1)));
    assign full      = (fill_reg >= n);

    assign stat.scan_done = hit_now || last;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        slot        = hit_idx_reg;
        ev_valid    = 1'b0;
        ev_page     = '0;
        faults_next = faults_reg;
        cnt_next    = CNT_W'(1);
        if (hit_reg)
        begin
            cnt_next = (hit_cnt_reg != COUNT_MAX) ? hit_cnt_reg + CNT_W'(1) : hit_cnt_reg;
        end
        else
        begin
            if (!full)
                slot = IDX_W'(fill_reg);
            else
            begin
                slot     = min_idx_reg;
                ev_valid = min_valid_reg;
                ev_page  = min_valid_reg ? min_page_reg : '0;
            end
            if (faults_reg != FAULT_MAX)
                faults_next = faults_reg + FAULT_W'(1);
        end
        out_data_next = {2'b00, faults_next, ev_page, ev_valid, FIDX_W'(slot), !hit_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frames_cfg_reg <= CFG_RESET;
        else if (cfg_we)
            frames_cfg_reg <= cfg_value;
    end

    // Scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= in_page;
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (hit_now)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_reg;
                hit_cnt_reg <= cur_cnt;
            end
            if ((idx_reg == '0) || (cur_cnt < min_cnt_reg))
            begin
                min_idx_reg   <= idx_reg;
                min_cnt_reg   <= cur_cnt;
                min_page_reg  <= cur_page;
                min_valid_reg <= cur_valid;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            count_mem[slot] <= cnt_next;
            if (!hit_reg)
                page_mem[slot] <= page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fill_reg   <= '0;
            faults_reg <= '0;
        end
        else if (cmd.commit && !hit_reg)
        begin
            valid_reg[slot] <= 1'b1;
            faults_reg      <= faults_next;
            if (!full)
                fill_reg <= fill_reg + NUM_W'(1);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/lfu_page_replacement_top.sv
// Top level of the LFU page replacement block.
// One page reference per input item, one result item per reference. An item
// is accepted, then the frames are scanned one per cycle through the frame
// store's single read port (up to and including the hit frame, or all managed
// frames on a miss), and then the update is committed into the result
// register. A held result does not block the next item; the commit waits
// only if the previous result is still untaken. frames_in_use is clamped to
// 1..16 and should be written only while the block is idle.
module lfu_page_replacement_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lfu_pkg::IN_TDATA_W-1:0]  s_tdata,  // [15:0] page_number
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] fault, [4:1] frame_index, [5] evicted_valid, [21:6] evicted_page,
    // [37:22] fault_count, [39:38] zero
    output logic [lfu_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lfu_pkg::CFG_W-1:0]       cfg_data  // [4:0] frames_in_use
);
    import lfu_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_page   (s_tdata[PAGE_W-1:0]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

>>> design/lfu_chk.sv
// Port-level checks for the LFU page replacement block, bound to the top level.
module lfu_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lfu_pkg::OUT_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous still in the scan");

    a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[0])
        else $error("eviction reported on a hit");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[37:22] != 16'd0)
        else $error("fault with zero fault count");

endmodule

bind lfu_page_replacement_top lfu_chk u_chk (.*);
